FILE: rtl/srv_pkg.sv
`default_nettype none

package srv_pkg;

	// Record layout
	localparam int RECORD_SIZE  = 828;
	localparam int KEY_LENGTH   = 8;
	localparam int OFFSET_W     = 12;
	localparam int CHECKSUM_W   = 32;
	localparam int CHECKSUM_BYTES = 4;
	localparam int MAGIC_BYTES  = 4;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX     = {OFFSET_W{1'b1}};
	localparam logic [OFFSET_W-1:0] RECORD_LAST    = OFFSET_W'(RECORD_SIZE - 1);
	localparam logic [OFFSET_W-1:0] RECORD_END     = OFFSET_W'(RECORD_SIZE);
	localparam logic [OFFSET_W-1:0] CHECKSUM_START = OFFSET_W'(RECORD_SIZE - CHECKSUM_BYTES);
	localparam logic [OFFSET_W-1:0] MAGIC_END      = OFFSET_W'(MAGIC_BYTES);
	localparam logic [OFFSET_W-1:0] MAGIC_LAST     = OFFSET_W'(MAGIC_BYTES - 1);

	localparam logic [CHECKSUM_W-1:0] SALT_RESET = 32'h7A69676D;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_MODE    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_SALT = 1'b1;

	typedef struct packed {
		logic [7:0] raw_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0]            plain_byte;
		logic [OFFSET_W-1:0]   byte_offset;
		logic                  in_record;
		logic                  verdict_valid;
		logic                  magic_good;
		logic                  sum_good;
		logic                  length_ok;
		logic                  accept;
		logic [CHECKSUM_W-1:0] computed_checksum;
	} out_item_t;

	// Repeating descramble key
	function automatic logic [7:0] key_byte(input logic [2:0] idx);
		logic [7:0] k;
		case (idx)
			3'd0: k = "S";
			3'd1: k = "i";
			3'd2: k = "g";
			3'd3: k = "m";
			3'd4: k = "a";
			3'd5: k = "Z";
			3'd6: k = "9";
			3'd7: k = "5";
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	// Expected file magic
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = "S";
			2'd1: m = "Z";
			2'd2: m = "R";
			2'd3: m = 8'h1A;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/scrambled_record_validator_core.sv
`default_nettype none

// Scrambled record validator. Takes a file one byte per item, descrambles each
// byte with the repeating 8-byte key, checks the 4-byte magic, keeps a salted
// shift-and-add checksum over the record body and compares it with the
// little-endian checksum stored in the last four record bytes. Every item
// yields one result; the end-of-file item carries the verdicts and returns the
// stream state to its start. One item per clock is sustained while the output
// is not stalled: an input register feeds the check logic, whose result lands
// in an output register; a stalled result holds the input register and stalls
// the input in the same cycle. The user must write configuration only while no
// item is in flight; the block does not enforce this. A new salt applies from
// the next file start.
module scrambled_record_validator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [srv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [srv_pkg::CHECKSUM_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire srv_pkg::in_item_t               in_item,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      srv_pkg::out_item_t              out_item
);
	import srv_pkg::*;

	logic       item_valid_s1;
	in_item_t   item_s1;
	logic       advance;
	out_item_t  result;
	logic       out_valid_q;
	out_item_t  out_item_q;

	assign advance  = item_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = item_valid_s1 && !advance;

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	srv_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.advance   (advance),
		.result    (result)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

FILE: rtl/srv_check.sv
`default_nettype none

module srv_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [srv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [srv_pkg::CHECKSUM_W-1:0]  cfg_data,
	input  wire srv_pkg::in_item_t             item,
	input  wire logic                          advance,
	output srv_pkg::out_item_t                 result
);
	import srv_pkg::*;

	logic                  force_mode_q;
	logic [CHECKSUM_W-1:0] salt_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [CHECKSUM_W-1:0] accum_q;
	logic [CHECKSUM_W-1:0] stored_q;
	logic                  magic_match_q;

	logic [OFFSET_W-1:0]   off;
	logic [7:0]            plain;
	logic [CHECKSUM_W-1:0] acc_base;
	logic [CHECKSUM_W-1:0] acc;
	logic [CHECKSUM_W-1:0] stored;
	logic                  mm;
	logic                  exact;
	logic                  longer;
	logic                  mok;
	logic                  cok;
	logic [1:0]            stored_pos;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_mode_q <= 1'b0;
			salt_q       <= SALT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FORCE_MODE:    force_mode_q <= cfg_data[0];
				CFG_CHECKSUM_SALT: salt_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Descramble and update the running checks
	always_comb begin
		off        = offset_q;
		plain      = item.raw_byte ^ key_byte(3'(off % KEY_LENGTH));
		acc_base   = (off == '0) ? salt_q : accum_q;
		acc        = acc_base;
		stored     = stored_q;
		mm         = magic_match_q;
		stored_pos = 2'(off - CHECKSUM_START);

		if (off < MAGIC_END && plain != magic_byte(off[1:0]))
			mm = 1'b0;

		if (off < CHECKSUM_START)
			acc = {acc_base[CHECKSUM_W-2:0], 1'b0} + CHECKSUM_W'(plain);
		else if (off < RECORD_END)
			stored = stored_q | (CHECKSUM_W'(plain) << {stored_pos, 3'b000});

		exact  = (off == RECORD_LAST);
		longer = (off >= RECORD_END);
		mok    = mm && (off >= MAGIC_LAST);
		cok    = (exact || longer) && (acc == stored);

		result.plain_byte        = plain;
		result.byte_offset       = off;
		result.in_record         = (off < RECORD_END);
		result.verdict_valid     = item.end_of_file;
		result.magic_good        = item.end_of_file && mok;
		result.sum_good          = item.end_of_file && cok;
		result.length_ok         = item.end_of_file && exact;
		result.accept            = item.end_of_file &&
			((exact && (force_mode_q || (mok && cok))) || (longer && force_mode_q));
		result.computed_checksum = acc;
	end

	// Advance stream state; clear it after the end-of-file item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= '0;
			accum_q       <= SALT_RESET;
			stored_q      <= '0;
			magic_match_q <= 1'b1;
		end else if (advance) begin
			if (item.end_of_file) begin
				offset_q      <= '0;
				accum_q       <= salt_q;
				stored_q      <= '0;
				magic_match_q <= 1'b1;
			end else begin
				offset_q      <= (off < OFFSET_MAX) ? off + 1'b1 : OFFSET_MAX;
				accum_q       <= acc;
				stored_q      <= stored;
				magic_match_q <= mm;
			end
		end
	end

endmodule

`default_nettype wire
